/* sv/tle_pkg.sv */
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, codes and controller/datapath interface types for the
// terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_MAX = 16;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    localparam int IDX_W    = $clog2(LINE_MAX);

    localparam logic [7:0] KEY_ENTER    = 8'd10;
    localparam logic [7:0] KEY_DELETE   = 8'd127;
    localparam logic [7:0] KEY_ESC      = 8'd27;
    localparam logic [7:0] KEY_BRACKET  = 8'd91;
    localparam logic [7:0] KEY_LEFT     = 8'd68;
    localparam logic [7:0] KEY_RIGHT    = 8'd67;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    typedef enum logic [1:0] {
        KIND_ECHO     = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_ENTER,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    typedef enum logic [2:0] {
        SRC_BUF,
        SRC_LINE,
        SRC_BS,
        SRC_SP,
        SRC_NL,
        SRC_OVF
    } src_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ESC,
        S_CSI,
        S_INS_TAIL,
        S_INS_BS,
        S_DEL_SP,
        S_DEL_BS,
        S_DEL_B1,
        S_DEL_S1,
        S_DEL_B2,
        S_DEL_TAIL,
        S_DEL_BS2,
        S_NL,
        S_LINE,
        S_LEFT,
        S_RIGHT,
        S_OVF
    } state_t;

    typedef struct packed {
        logic accept;
        op_t  op;
        logic emit;
        src_t src;
        logic last;
        logic cnt_load_t;
        logic cnt_dec;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic cur_zero;
        logic cur_at_end;
        logic t_zero;
        logic cnt_one;
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

/* sv/terminal_line_editor.sv */
// ----------------------------------------------------------------------------
// terminal_line_editor
// Keystroke line editor: edits a line buffer and emits echo bytes, line bytes and overflow notices.
// ----------------------------------------------------------------------------
// Usage:
//   Key channel (key_valid/key_ready, key): one keystroke byte per request.
//   Result channel (res_valid/res_ready, kind, byte_out, last): echo bytes
//   (kind 0), completed line bytes (kind 1) and the overflow notice (kind 2).
//   The final result caused by a key carries last = 1; a key that causes no
//   result (escape bytes, delete at line start) produces nothing at all.
//   One key is handled at a time: key_ready is high only while the sequencer
//   waits for a key, so a further key is taken only once every result of the
//   current key has been loaded into the output register. Results stream one
//   per cycle out of a single output register while it is free; the first is
//   loaded by the state that the sequencer enters after the key request is
//   accepted.
//   The rate is set by the single result register and the sequencer, which
//   emits one result per cycle while the output register is free.
//   When the receiver stalls, the current result holds and the sequencer
//   holds its place; nothing is lost or repeated.
//   Reset empties the line, clears the cursor and any pending escape.
//   Buffer contents are not cleared; only bytes below the length are read.
// ----------------------------------------------------------------------------
module terminal_line_editor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [7:0]  key,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  kind,
    output logic [7:0]  byte_out,
    output logic        last
);

    tle_pkg::cmd_t    cmd;
    tle_pkg::status_t status;

    // sequencer: decode keys, track escape phase, step through each echo run
    tle_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key       (key),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: buffer shifts, length/cursor, counters and result register
    tle_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .byte_out  (byte_out),
        .last      (last)
    );

endmodule

/* sv/tle_datapath.sv */
// ----------------------------------------------------------------------------
// tle_datapath
// Line buffer, length, cursor, emission counters and the result register.
// ----------------------------------------------------------------------------
module tle_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          key,
    input  tle_pkg::cmd_t       cmd,
    output tle_pkg::status_t    status,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          kind,
    output logic [7:0]          byte_out,
    output logic                last
);

    logic [7:0]                 buf_reg [tle_pkg::LINE_MAX];
    logic [7:0]                 buf_next [tle_pkg::LINE_MAX];
    logic [tle_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [tle_pkg::LEN_W-1:0]  cur_reg, cur_next;
    logic [tle_pkg::LEN_W-1:0]  t_reg, t_next;
    logic [tle_pkg::LEN_W-1:0]  cnt_reg, cnt_next;
    logic [tle_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [tle_pkg::LEN_W-1:0]  t_now;
    logic                       valid_reg, valid_next;
    tle_pkg::kind_t             kind_reg, kind_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       out_free;

    assign t_now    = len_reg - cur_reg;
    assign out_free = !valid_reg || res_ready;

    // line state and counters
    always_comb
    begin
        buf_next = buf_reg;
        len_next = len_reg;
        cur_next = cur_reg;
        t_next   = t_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            case (cmd.op)
                tle_pkg::OP_INSERT:
                begin
                    for (int i = 0; i < tle_pkg::LINE_MAX; i++)
                    begin
                        if (tle_pkg::LEN_W'(i) == cur_reg)
                        begin
                            buf_next[i] = key;
                        end
                        else if (tle_pkg::LEN_W'(i) > cur_reg && tle_pkg::LEN_W'(i) <= len_reg)
                        begin
                            buf_next[i] = buf_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    t_next   = t_now;
                    cnt_next = t_now + 1'b1;
                    idx_next = cur_reg[tle_pkg::IDX_W-1:0];
                    len_next = len_reg + 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
                tle_pkg::OP_DELETE:
                begin
                    for (int i = 0; i < tle_pkg::LINE_MAX; i++)
                    begin
                        if (tle_pkg::LEN_W'(i) + 1'b1 >= cur_reg
                            && tle_pkg::LEN_W'(i) + 1'b1 < len_reg)
                        begin
                            buf_next[i] = buf_reg[(i < tle_pkg::LINE_MAX - 1) ? i + 1 : i];
                        end
                    end
                    t_next   = t_now;
                    cnt_next = t_now;
                    idx_next = tle_pkg::IDX_W'(cur_reg - 1'b1);
                    len_next = len_reg - 1'b1;
                    cur_next = cur_reg - 1'b1;
                end
                tle_pkg::OP_ENTER:
                begin
                    cnt_next = len_reg;
                    idx_next = '0;
                    len_next = '0;
                    cur_next = '0;
                end
                tle_pkg::OP_LEFT:
                begin
                    cur_next = cur_reg - 1'b1;
                end
                tle_pkg::OP_RIGHT:
                begin
                    idx_next = cur_reg[tle_pkg::IDX_W-1:0];
                    cur_next = cur_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (cmd.cnt_load_t)
            begin
                cnt_next = t_reg;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            if (cmd.idx_inc)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // result register: load on emit, drop once taken
    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
            last_next  = cmd.last;
            case (cmd.src)
                tle_pkg::SRC_BUF:
                begin
                    kind_next = tle_pkg::KIND_ECHO;
                    byte_next = buf_reg[idx_reg];
                end
                tle_pkg::SRC_LINE:
                begin
                    kind_next = tle_pkg::KIND_LINE;
                    byte_next = buf_reg[idx_reg];
                end
                tle_pkg::SRC_BS:
                begin
                    kind_next = tle_pkg::KIND_ECHO;
                    byte_next = tle_pkg::CH_BACKSPACE;
                end
                tle_pkg::SRC_SP:
                begin
                    kind_next = tle_pkg::KIND_ECHO;
                    byte_next = tle_pkg::CH_SPACE;
                end
                tle_pkg::SRC_NL:
                begin
                    kind_next = tle_pkg::KIND_ECHO;
                    byte_next = tle_pkg::KEY_ENTER;
                end
                tle_pkg::SRC_OVF:
                begin
                    kind_next = tle_pkg::KIND_OVERFLOW;
                    byte_next = 8'd0;
                end
                default:
                begin
                    kind_next = tle_pkg::KIND_ECHO;
                    byte_next = 8'd0;
                end
            endcase
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            cur_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        t_reg    <= t_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign status.full       = (len_reg == tle_pkg::LEN_W'(tle_pkg::LINE_MAX));
    assign status.cur_zero   = (cur_reg == '0);
    assign status.cur_at_end = (cur_reg == len_reg);
    assign status.t_zero     = (t_reg == '0);
    assign status.cnt_one    = (cnt_reg == tle_pkg::LEN_W'(1));
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.out_free   = out_free;

    assign res_valid = valid_reg;
    assign kind      = kind_reg;
    assign byte_out  = byte_reg;
    assign last      = last_reg;

endmodule

/* sv/tle_ctrl.sv */
// ----------------------------------------------------------------------------
// tle_ctrl
// Key decoder and emission sequencer; escape phase is held in the state.
// ----------------------------------------------------------------------------
module tle_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_ready,
    input  logic [7:0]          key,
    input  tle_pkg::status_t    status,
    output tle_pkg::cmd_t       cmd
);

    tle_pkg::state_t state_reg, state_next;
    logic            accepting;
    logic            take;

    assign accepting = (state_reg == tle_pkg::S_IDLE) || (state_reg == tle_pkg::S_ESC)
                       || (state_reg == tle_pkg::S_CSI);
    assign take      = accepting && key_valid;
    assign key_ready = accepting;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tle_pkg::S_IDLE:
            begin
                if (key_valid)
                begin
                    if (key == tle_pkg::KEY_ESC)
                    begin
                        state_next = tle_pkg::S_ESC;
                    end
                    else if (key == tle_pkg::KEY_ENTER)
                    begin
                        state_next = tle_pkg::S_NL;
                    end
                    else if (key == tle_pkg::KEY_DELETE)
                    begin
                        if (!status.cur_zero)
                        begin
                            state_next = status.cur_at_end ? tle_pkg::S_DEL_B1
                                                           : tle_pkg::S_DEL_SP;
                        end
                    end
                    else if (status.full)
                    begin
                        state_next = tle_pkg::S_OVF;
                    end
                    else
                    begin
                        state_next = tle_pkg::S_INS_TAIL;
                    end
                end
            end
            tle_pkg::S_ESC:
            begin
                if (key_valid)
                begin
                    state_next = (key == tle_pkg::KEY_BRACKET) ? tle_pkg::S_CSI
                                                                : tle_pkg::S_IDLE;
                end
            end
            tle_pkg::S_CSI:
            begin
                if (key_valid)
                begin
                    if (key == tle_pkg::KEY_LEFT && !status.cur_zero)
                    begin
                        state_next = tle_pkg::S_LEFT;
                    end
                    else if (key == tle_pkg::KEY_RIGHT && !status.cur_at_end)
                    begin
                        state_next = tle_pkg::S_RIGHT;
                    end
                    else
                    begin
                        state_next = tle_pkg::S_IDLE;
                    end
                end
            end
            tle_pkg::S_INS_TAIL:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = status.t_zero ? tle_pkg::S_IDLE : tle_pkg::S_INS_BS;
                end
            end
            tle_pkg::S_INS_BS, tle_pkg::S_DEL_BS2, tle_pkg::S_LINE:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = tle_pkg::S_IDLE;
                end
            end
            tle_pkg::S_DEL_SP:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = tle_pkg::S_DEL_BS;
                end
            end
            tle_pkg::S_DEL_BS:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = tle_pkg::S_DEL_B1;
                end
            end
            tle_pkg::S_DEL_B1:
            begin
                if (status.out_free)
                begin
                    state_next = tle_pkg::S_DEL_S1;
                end
            end
            tle_pkg::S_DEL_S1:
            begin
                if (status.out_free)
                begin
                    state_next = tle_pkg::S_DEL_B2;
                end
            end
            tle_pkg::S_DEL_B2:
            begin
                if (status.out_free)
                begin
                    state_next = status.t_zero ? tle_pkg::S_IDLE : tle_pkg::S_DEL_TAIL;
                end
            end
            tle_pkg::S_DEL_TAIL:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = tle_pkg::S_DEL_BS2;
                end
            end
            tle_pkg::S_NL:
            begin
                if (status.out_free)
                begin
                    state_next = status.cnt_zero ? tle_pkg::S_IDLE : tle_pkg::S_LINE;
                end
            end
            tle_pkg::S_LEFT, tle_pkg::S_RIGHT, tle_pkg::S_OVF:
            begin
                if (status.out_free)
                begin
                    state_next = tle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = tle_pkg::OP_NONE;
        cmd.src        = tle_pkg::SRC_BS;
        cmd.accept     = take;
        case (state_reg)
            tle_pkg::S_IDLE:
            begin
                if (key == tle_pkg::KEY_ENTER)
                begin
                    cmd.op = tle_pkg::OP_ENTER;
                end
                else if (key == tle_pkg::KEY_DELETE)
                begin
                    cmd.op = status.cur_zero ? tle_pkg::OP_NONE : tle_pkg::OP_DELETE;
                end
                else if (key != tle_pkg::KEY_ESC && !status.full)
                begin
                    cmd.op = tle_pkg::OP_INSERT;
                end
            end
            tle_pkg::S_ESC:
            begin
            end
            tle_pkg::S_CSI:
            begin
                if (key == tle_pkg::KEY_LEFT && !status.cur_zero)
                begin
                    cmd.op = tle_pkg::OP_LEFT;
                end
                else if (key == tle_pkg::KEY_RIGHT && !status.cur_at_end)
                begin
                    cmd.op = tle_pkg::OP_RIGHT;
                end
            end
            tle_pkg::S_INS_TAIL, tle_pkg::S_DEL_TAIL:
            begin
                cmd.emit    = status.out_free;
                cmd.src     = tle_pkg::SRC_BUF;
                cmd.idx_inc = status.out_free;
                cmd.cnt_dec = status.out_free;
                cmd.cnt_load_t = status.out_free && status.cnt_one;
                cmd.last    = (state_reg == tle_pkg::S_INS_TAIL) && status.cnt_one
                              && status.t_zero;
            end
            tle_pkg::S_INS_BS, tle_pkg::S_DEL_BS2:
            begin
                cmd.emit    = status.out_free;
                cmd.src     = tle_pkg::SRC_BS;
                cmd.cnt_dec = status.out_free;
                cmd.last    = status.cnt_one;
            end
            tle_pkg::S_DEL_SP:
            begin
                cmd.emit       = status.out_free;
                cmd.src        = tle_pkg::SRC_SP;
                cmd.cnt_dec    = status.out_free;
                cmd.cnt_load_t = status.out_free && status.cnt_one;
            end
            tle_pkg::S_DEL_BS:
            begin
                cmd.emit    = status.out_free;
                cmd.src     = tle_pkg::SRC_BS;
                cmd.cnt_dec = status.out_free;
            end
            tle_pkg::S_DEL_B1:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_BS;
            end
            tle_pkg::S_DEL_S1:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_SP;
            end
            tle_pkg::S_DEL_B2:
            begin
                cmd.emit       = status.out_free;
                cmd.src        = tle_pkg::SRC_BS;
                cmd.last       = status.t_zero;
                cmd.cnt_load_t = status.out_free;
            end
            tle_pkg::S_NL:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_NL;
                cmd.last = status.cnt_zero;
            end
            tle_pkg::S_LINE:
            begin
                cmd.emit    = status.out_free;
                cmd.src     = tle_pkg::SRC_LINE;
                cmd.idx_inc = status.out_free;
                cmd.cnt_dec = status.out_free;
                cmd.last    = status.cnt_one;
            end
            tle_pkg::S_LEFT:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_BS;
                cmd.last = 1'b1;
            end
            tle_pkg::S_RIGHT:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_BUF;
                cmd.last = 1'b1;
            end
            tle_pkg::S_OVF:
            begin
                cmd.emit = status.out_free;
                cmd.src  = tle_pkg::SRC_OVF;
                cmd.last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tle_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/tle_checker.sv */
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks for the terminal line editor, bound to the top level.
// ----------------------------------------------------------------------------
module tle_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        key_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  kind,
    input logic [7:0]  byte_out,
    input logic        last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(byte_out)
                                    && $stable(last))
    else $error("stalled result changed");

    // key_ready is low while a non-final result of a key is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !key_ready)
    else $error("key taken before the last result");

    // the overflow notice is a lone, zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == tle_pkg::KIND_OVERFLOW |-> byte_out == 8'd0 && last)
    else $error("malformed overflow notice");

    // a taken line byte that is not the last is followed by another line byte or by no result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last && kind == tle_pkg::KIND_LINE
        |=> !res_valid || kind == tle_pkg::KIND_LINE)
    else $error("line byte run interrupted");

endmodule

bind terminal_line_editor tle_checker u_checker (.*);
